// ===== rtl/dlpb_pkg.sv =====
`default_nettype none

package dlpb_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int SIZE_W     = 7;
    localparam int CMP_W      = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;
    localparam int LEASE_W    = 32;
    localparam int XID_W      = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;
    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 144;

    localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

    localparam logic FUNC_DISCOVER = 1'b0;
    localparam logic FUNC_REQUEST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEASE_TIME = 2'd2;

    localparam logic [IP_W-1:0]    POOL_BASE_RST  = 32'd3232235876;
    localparam logic [SIZE_W-1:0]  POOL_SIZE_RST  = 7'd64;
    localparam logic [LEASE_W-1:0] LEASE_TIME_RST = 32'd86400;

    // Scan token that walks down the cell row
    typedef struct packed {
        logic             valid;
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             req_hit;
    } tok_t;

    // Query held steady for the whole scan
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [SIZE_W-1:0] size;
        logic              off_ok;
        logic [IDX_W-1:0]  off_idx;
    } query_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [MAC_W-1:0] mac;
    } wr_t;

endpackage

`default_nettype wire

// ===== rtl/dhcp_lease_pool_binder_core.sv =====
// Address pool binder for a DHCP-style server.
// Input stream (s_axis_*): one message per transaction, tuser carries the
// message kind (discover or request), tdata the MAC, requested address and
// transaction id. Output stream (m_axis_*): exactly one reply per message,
// tuser carries offer / ack / no-reply, tdata the address, lease, id, MAC.
// Configuration (cfg_we, cfg_idx, cfg_wdata) sets pool base, pool size and
// lease time; write only while no message is in flight.
// Each message runs a scan token along a row of POOL_DEPTH lease cells, one
// cell per cycle; the result is registered at the end of the row and then
// moves to the output register.
// The block handles one message at a time; s_axis_tready is high only when
// idle. A finished reply waits in the output register while m_axis_tready
// is low; the scan of the next message still runs, and its result is held
// until the output register frees.
// Reset clears all lease marks and loads the default configuration; the
// block is ready in the first cycle after reset.
`default_nettype none

module dhcp_lease_pool_binder_core
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [dlpb_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire [dlpb_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // client_mac[47:0], requested_ip[79:48], transaction_id[111:80]
    input  wire [dlpb_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // func[0]
    input  wire [0:0]                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // assigned_ip[31:0], reply_lease[63:32], reply_xid[95:64], reply_mac[143:96]
    output logic [dlpb_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // reply_kind[1:0]
    output logic [dlpb_pkg::KIND_W-1:0]        m_axis_tuser
);
    import dlpb_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [IP_W-1:0]    pool_base_reg;
    logic [SIZE_W-1:0]  pool_size_reg;
    logic [LEASE_W-1:0] lease_time_reg;

    logic               func_reg;
    logic [MAC_W-1:0]   mac_reg;
    logic [IP_W-1:0]    req_reg;
    logic [XID_W-1:0]   xid_reg;
    logic               off_ok_reg;
    logic [IDX_W-1:0]   off_idx_reg;
    logic               inject_reg;

    logic [KIND_W-1:0]  res_kind_reg, res_kind_next;
    logic [IP_W-1:0]    res_ip_reg, res_ip_next;
    logic [LEASE_W-1:0] res_lease_reg, res_lease_next;

    logic               m_valid_reg;
    logic [KIND_W-1:0]  m_kind_reg;
    logic [IP_W-1:0]    m_ip_reg;
    logic [LEASE_W-1:0] m_lease_reg;
    logic [XID_W-1:0]   m_xid_reg;
    logic [MAC_W-1:0]   m_mac_reg;

    logic               s_accept;
    logic               out_free;
    logic               load_out;
    logic [IP_W-1:0]    in_req;
    logic [IP_W-1:0]    in_off;
    logic               in_off_ok;
    logic               scan_end;
    logic [IDX_W-1:0]   pick_idx;

    query_t query;
    wr_t    wr;
    tok_t   tok_head;
    tok_t   tok_tail;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign load_out      = (state_reg == ST_DONE) && out_free;
    assign scan_end      = (state_reg == ST_SCAN) && tok_tail.valid;

    // Offset into the pool, modulo 2^32
    assign in_req    = s_axis_tdata[79:48];
    assign in_off    = in_req - pool_base_reg;
    assign in_off_ok = (in_off < IP_W'(pool_size_reg)) && (in_off < IP_W'(POOL_DEPTH));

    assign query.mac     = mac_reg;
    assign query.size    = pool_size_reg;
    assign query.off_ok  = off_ok_reg;
    assign query.off_idx = off_idx_reg;

    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = inject_reg;
    end

    // Bind the lowest free entry when a discover finds no existing lease
    assign wr.en  = scan_end && (func_reg == FUNC_DISCOVER) &&
                    !tok_tail.match_found && tok_tail.free_found;
    assign wr.idx = tok_tail.free_idx;
    assign wr.mac = mac_reg;

    assign pick_idx = tok_tail.match_found ? tok_tail.match_idx : tok_tail.free_idx;

    dlpb_chain u_chain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query),
        .wr      (wr),
        .tok_in  (tok_head),
        .tok_out (tok_tail)
    );

    always_comb
    begin
        res_kind_next  = KIND_NONE;
        res_ip_next    = '0;
        res_lease_next = '0;
        if (func_reg == FUNC_DISCOVER)
        begin
            if (tok_tail.match_found || tok_tail.free_found)
            begin
                res_kind_next  = KIND_OFFER;
                res_ip_next    = pool_base_reg + IP_W'(pick_idx);
                res_lease_next = lease_time_reg;
            end
        end
        else if (tok_tail.req_hit)
        begin
            res_kind_next  = KIND_ACK;
            res_ip_next    = req_reg;
            res_lease_next = lease_time_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_tail.valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            inject_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            pool_base_reg  <= POOL_BASE_RST;
            pool_size_reg  <= POOL_SIZE_RST;
            lease_time_reg <= LEASE_TIME_RST;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= s_accept;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_POOL_BASE:  pool_base_reg  <= cfg_wdata[IP_W-1:0];
                    REG_POOL_SIZE:  pool_size_reg  <= cfg_wdata[SIZE_W-1:0];
                    REG_LEASE_TIME: lease_time_reg <= cfg_wdata[LEASE_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            func_reg    <= s_axis_tuser[0];
            mac_reg     <= s_axis_tdata[47:0];
            req_reg     <= in_req;
            xid_reg     <= s_axis_tdata[111:80];
            off_ok_reg  <= in_off_ok;
            off_idx_reg <= in_off[IDX_W-1:0];
        end
        if (scan_end)
        begin
            res_kind_reg  <= res_kind_next;
            res_ip_reg    <= res_ip_next;
            res_lease_reg <= res_lease_next;
        end
        if (load_out)
        begin
            m_kind_reg  <= res_kind_reg;
            m_ip_reg    <= res_ip_reg;
            m_lease_reg <= res_lease_reg;
            m_xid_reg   <= xid_reg;
            m_mac_reg   <= mac_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {m_mac_reg, m_xid_reg, m_lease_reg, m_ip_reg};

endmodule

`default_nettype wire

// ===== rtl/dlpb_cell.sv =====
`default_nettype none

module dlpb_cell
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire [dlpb_pkg::IDX_W-1:0] my_idx,
    input  dlpb_pkg::query_t      query,
    input  dlpb_pkg::wr_t         wr,
    input  dlpb_pkg::tok_t        tok_in,
    output dlpb_pkg::tok_t        tok_out
);
    import dlpb_pkg::*;

    logic             valid_reg;
    logic [MAC_W-1:0] owner_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             in_pool;
    logic             hit;
    logic             wr_here;

    assign in_pool = CMP_W'(my_idx) < CMP_W'(query.size);
    assign hit     = in_pool && valid_reg && (owner_reg == query.mac);
    assign wr_here = wr.en && (wr.idx == my_idx);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.match_found && hit)
        begin
            tok_next.match_found = 1'b1;
            tok_next.match_idx   = my_idx;
        end
        if (!tok_in.free_found && in_pool && !valid_reg)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = my_idx;
        end
        if (hit && query.off_ok && (query.off_idx == my_idx))
        begin
            tok_next.req_hit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            owner_reg <= wr.mac;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/dlpb_chain.sv =====
`default_nettype none

module dlpb_chain
(
    input  wire               clk,
    input  wire               rst_n,
    input  dlpb_pkg::query_t  query,
    input  dlpb_pkg::wr_t     wr,
    input  dlpb_pkg::tok_t    tok_in,
    output dlpb_pkg::tok_t    tok_out
);
    import dlpb_pkg::*;

    tok_t tok_link [POOL_DEPTH+1];

    assign tok_link[0] = tok_in;

    genvar g;
    generate
        for (g = 0; g < POOL_DEPTH; g++)
        begin : g_cell
            dlpb_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .my_idx  (IDX_W'(g)),
                .query   (query),
                .wr      (wr),
                .tok_in  (tok_link[g]),
                .tok_out (tok_link[g+1])
            );
        end
    endgenerate

    assign tok_out = tok_link[POOL_DEPTH];

endmodule

`default_nettype wire

// ===== rtl/dlpb_checker.sv =====
`default_nettype none

module dlpb_checker
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    input  wire                                s_axis_tready,
    input  wire                                m_axis_tvalid,
    input  wire                                m_axis_tready,
    input  wire [dlpb_pkg::M_DATA_W-1:0]       m_axis_tdata,
    input  wire [dlpb_pkg::KIND_W-1:0]         m_axis_tuser
);
    import dlpb_pkg::*;

    // Hold a stalled reply
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled reply changed");

    // No reply carries neither address nor lease
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_NONE) |-> (m_axis_tdata[63:0] == '0))
        else $error("no-reply with address or lease");

    // One message at a time: busy after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted while busy");

    // A reply cannot appear right after a message is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("reply too early");

endmodule

bind dhcp_lease_pool_binder_core dlpb_checker u_dlpb_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import dlpb_pkg::*;

    localparam int NUM_CLIENTS = 72;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IP_W-1:0]    ip;
        logic [LEASE_W-1:0] lease;
        logic [XID_W-1:0]   xid;
        logic [MAC_W-1:0]   mac;
    } reply_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // client_mac[47:0], requested_ip[79:48], transaction_id[111:80]
    logic [S_DATA_W-1:0]   s_axis_tdata;
    // func[0]
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // assigned_ip[31:0], reply_lease[63:32], reply_xid[95:64], reply_mac[143:96]
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // reply_kind[1:0]
    logic [KIND_W-1:0]     m_axis_tuser;

    // Shadow of the lease table and the registers
    logic                  lease_held [POOL_DEPTH];
    logic [MAC_W-1:0]      lease_mac [POOL_DEPTH];
    logic [IP_W-1:0]       cur_base;
    logic [SIZE_W-1:0]     cur_size;
    logic [LEASE_W-1:0]    cur_lease;

    logic [MAC_W-1:0]      client_macs [NUM_CLIENTS];
    reply_t                replies_due [$];

    int  errors;
    int  n_sent;
    int  n_offer;
    int  n_ack;
    int  n_none;
    int  n_size_writes;
    int  n_base_writes;
    int  rx_hold;
    int  longest_hold;
    bit  fast_tx;
    bit  fast_rx;

    dhcp_lease_pool_binder_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("timeout at %0t, %0d replies still outstanding", $time, replies_due.size());
        $display("tb NOT OK");
        $finish;
    end

    // Offer the owned entry, else bind the lowest free one; ack only an owned address
    function automatic reply_t bind_or_ack(input logic f, input logic [MAC_W-1:0] mac,
                                           input logic [IP_W-1:0] req,
                                           input logic [XID_W-1:0] xid);
        reply_t      r;
        int          n;
        int          hit;
        int          i;
        logic [31:0] off;
        r.kind  = KIND_NONE;
        r.ip    = '0;
        r.lease = '0;
        r.xid   = xid;
        r.mac   = mac;
        n   = (cur_size < POOL_DEPTH) ? cur_size : POOL_DEPTH;
        hit = -1;
        if (f == FUNC_DISCOVER)
        begin
            for (i = 0; i < n; i++)
                if (hit < 0 && lease_held[i] && lease_mac[i] == mac)
                    hit = i;
            for (i = 0; i < n; i++)
                if (hit < 0 && !lease_held[i])
                begin
                    hit           = i;
                    lease_held[i] = 1'b1;
                    lease_mac[i]  = mac;
                end
            if (hit >= 0)
            begin
                r.kind  = KIND_OFFER;
                r.ip    = cur_base + hit;
                r.lease = cur_lease;
            end
        end
        else
        begin
            // membership wraps modulo 2^32
            off = req - cur_base;
            if (off < n && lease_held[off[IDX_W-1:0]] && lease_mac[off[IDX_W-1:0]] == mac)
            begin
                r.kind  = KIND_ACK;
                r.ip    = req;
                r.lease = cur_lease;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : reply_check
        reply_t seen;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.kind  = m_axis_tuser;
            seen.ip    = m_axis_tdata[31:0];
            seen.lease = m_axis_tdata[63:32];
            seen.xid   = m_axis_tdata[95:64];
            seen.mac   = m_axis_tdata[143:96];
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, got kind %0d ip %h xid %h",
                         $time, seen.kind, seen.ip, seen.xid);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("reply_kind", want.kind, seen.kind);
                check_field("assigned_ip", want.ip, seen.ip);
                check_field("reply_lease", want.lease, seen.lease);
                check_field("reply_xid", want.xid, seen.xid);
                check_field("reply_mac", want.mac, seen.mac);
                if (want.kind == KIND_OFFER)
                    n_offer++;
                else if (want.kind == KIND_ACK)
                    n_ack++;
                else
                    n_none++;
            end
        end
    end

    // Output side: random stall before each reply, or a long hold when asked
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
                stall = fast_rx ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_msg(input logic f, input logic [MAC_W-1:0] mac,
                            input logic [IP_W-1:0] req, input logic [XID_W-1:0] xid);
        int     gap;
        reply_t due;
        gap = fast_tx ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {xid, req, mac};
        s_axis_tuser  <= f;
        do @(posedge clk); while (!s_axis_tready);
        due         = bind_or_ack(f, mac, req, xid);
        replies_due = {replies_due, due};
        n_sent++;
    endtask

    // Hold the input until every reply is back and the scan has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_POOL_BASE:
            begin
                cur_base = data;
                n_base_writes++;
            end
            REG_POOL_SIZE:
            begin
                cur_size = data[SIZE_W-1:0];
                n_size_writes++;
            end
            REG_LEASE_TIME:  cur_lease = data;
            default:         ;
        endcase
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    // Mostly known clients and owned addresses, some strangers and stray addresses
    task automatic random_msg();
        logic              f;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   req;
        int                pick;
        logic [IDX_W-1:0]  idx;
        f    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        idx  = IDX_W'($urandom_range(0, POOL_DEPTH - 1));
        if (pick < 45 && lease_held[idx])
            mac = lease_mac[idx];
        else if (pick < 90)
            mac = client_macs[$urandom_range(0, NUM_CLIENTS - 1)];
        else
            mac = random_mac();
        pick = $urandom_range(0, 99);
        if (f == FUNC_DISCOVER)
            req = $urandom;
        else if (pick < 60)
        begin
            if (lease_held[idx])
                mac = lease_mac[idx];
            req = cur_base + IP_W'(idx);
        end
        else if (pick < 85)
            req = cur_base + $urandom_range(0, POOL_DEPTH + 6);
        else
            req = $urandom;
        send_msg(f, mac, req, $urandom);
    endtask

    task automatic test_first_bindings();
        logic [MAC_W-1:0] mac_a;
        mac_a = 48'h0242_AC11_0002;
        send_msg(FUNC_DISCOVER, mac_a, $urandom, 32'h0000_0000);
        send_msg(FUNC_DISCOVER, mac_a, $urandom, 32'hFFFF_FFFF);
        send_msg(FUNC_DISCOVER, {MAC_W{1'b1}}, $urandom, $urandom);
        send_msg(FUNC_DISCOVER, {MAC_W{1'b0}}, $urandom, $urandom);
        send_msg(FUNC_REQUEST, mac_a, cur_base, $urandom);
        send_msg(FUNC_REQUEST, mac_a, cur_base + 32'd1, $urandom);
        send_msg(FUNC_REQUEST, mac_a, cur_base - 32'd1, $urandom);
        send_msg(FUNC_REQUEST, {MAC_W{1'b0}}, 32'hFFFF_FFFF, $urandom);
        send_msg(FUNC_REQUEST, mac_a, cur_base + POOL_DEPTH, $urandom);
        settle();
    endtask

    task automatic test_pool_limits();
        // shrink below the bound entries: pool full, third lease hidden
        write_reg(REG_POOL_SIZE, 2);
        send_msg(FUNC_DISCOVER, 48'h0242_AC11_0003, $urandom, $urandom);
        send_msg(FUNC_REQUEST, {MAC_W{1'b0}}, cur_base + 32'd2, $urandom);
        send_msg(FUNC_DISCOVER, {MAC_W{1'b0}}, $urandom, $urandom);
        settle();
        write_reg(REG_POOL_SIZE, 0);
        send_msg(FUNC_DISCOVER, 48'h0242_AC11_0002, $urandom, $urandom);
        send_msg(FUNC_REQUEST, 48'h0242_AC11_0002, cur_base, $urandom);
        settle();
        // size above the table depth; the hidden lease comes back
        write_reg(REG_POOL_SIZE, 127);
        send_msg(FUNC_REQUEST, {MAC_W{1'b0}}, cur_base + 32'd2, $urandom);
        send_msg(FUNC_DISCOVER, 48'h0242_AC11_0003, $urandom, $urandom);
        settle();
    endtask

    task automatic test_base_wrap();
        write_reg(REG_POOL_BASE, 32'hFFFF_FFFE);
        write_reg(REG_LEASE_TIME, 32'h0000_0000);
        send_msg(FUNC_REQUEST, 48'h0242_AC11_0002, 32'hFFFF_FFFE, $urandom);
        send_msg(FUNC_DISCOVER, 48'h0242_AC11_0004, $urandom, $urandom);
        send_msg(FUNC_REQUEST, 48'h0242_AC11_0004, 32'h0000_0002, $urandom);
        send_msg(FUNC_REQUEST, {MAC_W{1'b1}}, 32'hFFFF_FFFF, $urandom);
        settle();
        write_reg(REG_LEASE_TIME, 32'hFFFF_FFFF);
        send_msg(FUNC_DISCOVER, {MAC_W{1'b1}}, $urandom, $urandom);
        settle();
    endtask

    task automatic test_random_traffic(input int rounds, input int size,
                                       input logic [IP_W-1:0] base,
                                       input logic [LEASE_W-1:0] lease);
        int k;
        write_reg(REG_POOL_SIZE, size);
        write_reg(REG_POOL_BASE, base);
        write_reg(REG_LEASE_TIME, lease);
        for (k = 0; k < rounds; k++)
        begin
            if (k % 50 == 0)
            begin
                fast_tx = ($urandom_range(0, 3) == 0);
                fast_rx = ($urandom_range(0, 3) == 0);
            end
            random_msg();
        end
        settle();
    endtask

    // Stall the output for a long stretch while messages keep coming
    task automatic test_backpressure();
        int k;
        fast_tx      = 1'b1;
        rx_hold      = 400;
        longest_hold = 400;
        for (k = 0; k < 16; k++)
            random_msg();
        fast_tx = 1'b0;
        settle();
    endtask

    initial
    begin
        int i;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_POOL_BASE;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_DISCOVER;
        errors        = 0;
        n_sent        = 0;
        n_offer       = 0;
        n_ack         = 0;
        n_none        = 0;
        n_size_writes = 0;
        n_base_writes = 0;
        rx_hold       = 0;
        longest_hold  = 0;
        fast_tx       = 1'b0;
        fast_rx       = 1'b0;
        cur_base      = POOL_BASE_RST;
        cur_size      = POOL_SIZE_RST;
        cur_lease     = LEASE_TIME_RST;
        for (i = 0; i < POOL_DEPTH; i++)
        begin
            lease_held[i] = 1'b0;
            lease_mac[i]  = '0;
        end
        for (i = 0; i < NUM_CLIENTS; i++)
            client_macs[i] = random_mac();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_bindings();
        test_pool_limits();
        test_base_wrap();
        test_random_traffic(200, 8, $urandom, $urandom);
        test_random_traffic(120, 1, 32'h0000_0000, 32'h0000_0000);
        test_random_traffic(200, 24, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        test_backpressure();
        test_random_traffic(220, 64, $urandom, $urandom);
        test_random_traffic(200, 40, $urandom, $urandom);
        test_random_traffic(200, 127, $urandom, $urandom);
        test_random_traffic(200, $urandom_range(1, 64), $urandom, $urandom);
        test_random_traffic(320, 64, $urandom, LEASE_TIME_RST);

        repeat (POOL_DEPTH + 16) @(posedge clk);
        $display("covered %0d messages: %0d offers, %0d acks, %0d without reply",
                 n_sent, n_offer, n_ack, n_none);
        $display("over %0d pool sizes and %0d base moves, with a %0d-cycle output stall",
                 n_size_writes, n_base_writes, longest_hold);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
